@@ sv/tltp_pkg.sv @@
// ----------------------------------------------------------------------------
// tltp_pkg
// Types, constants and interval tables shared by the throttle policy modules.
// ----------------------------------------------------------------------------
package tltp_pkg;

  localparam int unsigned TIME_BITS = 48;

  localparam logic [7:0]  MAX_ESCALATIONS      = 8'd3;
  localparam logic [31:0] ESCALATION_WINDOW_MS = 32'd60000;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_ENTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_EXIT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_ENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_EXIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ENTER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_EXIT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 3'd7;

  // mode codes
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_PRESSURE = 3'd1;
  localparam logic [2:0] MODE_THERMAL  = 3'd2;
  localparam logic [2:0] MODE_CRITICAL = 3'd3;
  localparam logic [2:0] MODE_RECOVERY = 3'd4;

  localparam logic [1:0] LAST_STAGE      = 2'd2;
  localparam logic [3:0] PAUSED_INTERVAL = 4'd15;
  localparam logic [7:0] ESC_COUNT_MAX   = 8'hFF;

  typedef logic [TIME_BITS-1:0] time_t;
  // packed interval table: {low[3:0], mid[1:0], high}
  typedef logic [6:0] tab_t;

  typedef struct packed {
    logic signed [7:0] temperature;
    logic signed [7:0] cpu_load;
    time_t             timestamp;
  } in_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       high_tier_interval;
    logic [1:0] mid_tier_interval;
    logic [3:0] low_tier_interval;
    logic       changed;
  } out_t;

  typedef struct packed {
    logic [6:0]  crit_enter;
    logic [6:0]  crit_exit;
    logic [6:0]  thermal_enter;
    logic [6:0]  thermal_exit;
    logic [6:0]  load_enter;
    logic [6:0]  load_exit;
    logic [31:0] min_hold;
    logic [31:0] cooldown;
  } cfg_t;

  // policy state visible to the top level
  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] stage;
    logic [7:0] esc_count;
  } pol_stat_t;

  function automatic tab_t pack_tab(logic hi, logic [1:0] mid, logic [3:0] lo);
    return {lo, mid, hi};
  endfunction

  function automatic tab_t table_of(logic [2:0] mode, logic [1:0] stage);
    tab_t t;
    case (mode)
      MODE_NORMAL:   t = pack_tab(1'b0, 2'd0, 4'd0);
      MODE_PRESSURE: t = pack_tab(1'b0, 2'd1, 4'd2);
      MODE_THERMAL:  t = pack_tab(1'b0, 2'd2, 4'd3);
      MODE_CRITICAL: t = pack_tab(1'b1, 2'd3, PAUSED_INTERVAL);
      MODE_RECOVERY: begin
        case (stage)
          2'd0:    t = pack_tab(1'b0, 2'd1, 4'd2);
          2'd1:    t = pack_tab(1'b0, 2'd0, 4'd1);
          default: t = pack_tab(1'b0, 2'd0, 4'd0);
        endcase
      end
      default:       t = '0;
    endcase
    return t;
  endfunction

endpackage

@@ sv/tltp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tltp_cfg_regs
// Threshold and timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tltp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tltp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tltp_pkg::CFG_W-1:0]     cfg_wdata_i,
  output tltp_pkg::cfg_t                cfg_o
);
  import tltp_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CRIT_ENTER:    cfg_d.crit_enter    = cfg_wdata_i[6:0];
        CFG_CRIT_EXIT:     cfg_d.crit_exit     = cfg_wdata_i[6:0];
        CFG_THERMAL_ENTER: cfg_d.thermal_enter = cfg_wdata_i[6:0];
        CFG_THERMAL_EXIT:  cfg_d.thermal_exit  = cfg_wdata_i[6:0];
        CFG_LOAD_ENTER:    cfg_d.load_enter    = cfg_wdata_i[6:0];
        CFG_LOAD_EXIT:     cfg_d.load_exit     = cfg_wdata_i[6:0];
        CFG_MIN_HOLD:      cfg_d.min_hold      = cfg_wdata_i;
        CFG_COOLDOWN:      cfg_d.cooldown      = cfg_wdata_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crit_enter    <= 7'd95;
      cfg_q.crit_exit     <= 7'd85;
      cfg_q.thermal_enter <= 7'd80;
      cfg_q.thermal_exit  <= 7'd70;
      cfg_q.load_enter    <= 7'd90;
      cfg_q.load_exit     <= 7'd70;
      cfg_q.min_hold      <= 32'd2000;
      cfg_q.cooldown      <= 32'd5000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/tltp_policy.sv @@
// ----------------------------------------------------------------------------
// tltp_policy
// Mode state machine, escalation budget and recovery stages. Computes the
// result for the registered sample and commits the new state on fire_i.
// ----------------------------------------------------------------------------
module tltp_policy (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tltp_pkg::cfg_t       cfg_i,
  input  tltp_pkg::in_t        item_i,
  input  logic                 fire_i,
  output tltp_pkg::out_t       res_o,
  output tltp_pkg::pol_stat_t  stat_o
);
  import tltp_pkg::*;

  logic [2:0] mode_q, mode_d;
  time_t      since_q, since_d;
  time_t      cd_until_q, cd_until_d;
  time_t      win_start_q, win_start_d;
  logic [7:0] esc_q, esc_d;
  logic [1:0] stage_q, stage_d;
  tab_t       last_tab_q, tab;

  time_t      now;
  logic       temp_ok, load_ok;
  logic       hot_crit, hot, cooled, cooled_crit, load_high, cpu_low;
  time_t      elapsed, win_diff;
  logic       held, cool_ok, roll, budget;
  logic [7:0] esc_eff;
  logic [TIME_BITS:0] cd_sum;
  time_t      cd_end;
  logic       go, stage_step;
  logic [2:0] go_mode;

  assign now     = item_i.timestamp;
  // negative reading = missing
  assign temp_ok = !item_i.temperature[7];
  assign load_ok = !item_i.cpu_load[7];

  assign hot_crit    = temp_ok && (item_i.temperature[6:0] >= cfg_i.crit_enter);
  assign hot         = temp_ok && (item_i.temperature[6:0] >= cfg_i.thermal_enter);
  assign cooled      = !temp_ok || (item_i.temperature[6:0] <= cfg_i.thermal_exit);
  assign cooled_crit = !temp_ok || (item_i.temperature[6:0] <= cfg_i.crit_exit);
  assign load_high   = load_ok && (item_i.cpu_load[6:0] >= cfg_i.load_enter);
  assign cpu_low     = !load_ok || (item_i.cpu_load[6:0] <= cfg_i.load_exit);

  assign elapsed = now - since_q;
  assign held    = elapsed >= TIME_BITS'(cfg_i.min_hold);
  assign cool_ok = now >= cd_until_q;

  // window roll: exact compare, no wrap
  assign win_diff = now - win_start_q;
  assign roll     = (now >= win_start_q) && (win_diff >= TIME_BITS'(ESCALATION_WINDOW_MS));
  assign esc_eff  = roll ? 8'd0 : esc_q;
  assign budget   = esc_eff < MAX_ESCALATIONS;

  // saturating cooldown end
  assign cd_sum = {1'b0, now} + (TIME_BITS + 1)'(cfg_i.cooldown);
  assign cd_end = cd_sum[TIME_BITS] ? '1 : cd_sum[TIME_BITS-1:0];

  always_comb begin
    go         = 1'b0;
    go_mode    = MODE_NORMAL;
    stage_step = 1'b0;
    case (mode_q)
      MODE_NORMAL: begin
        if (hot_crit) begin
          go = 1'b1; go_mode = MODE_CRITICAL;
        end else if (cool_ok) begin
          if (hot && held && budget) begin
            go = 1'b1; go_mode = MODE_THERMAL;
          end else if (load_high && held && budget) begin
            go = 1'b1; go_mode = MODE_PRESSURE;
          end
        end
      end
      MODE_PRESSURE: begin
        if (hot_crit) begin
          go = 1'b1; go_mode = MODE_CRITICAL;
        end else if (hot && held && budget) begin
          go = 1'b1; go_mode = MODE_THERMAL;
        end else if (cpu_low && held) begin
          go = 1'b1; go_mode = MODE_RECOVERY;
        end
      end
      MODE_THERMAL: begin
        if (hot_crit) begin
          go = 1'b1; go_mode = MODE_CRITICAL;
        end else if (cooled && held) begin
          go = 1'b1; go_mode = MODE_RECOVERY;
        end
      end
      MODE_CRITICAL: begin
        if (cooled_crit && held) begin
          go = 1'b1; go_mode = MODE_RECOVERY;
        end
      end
      MODE_RECOVERY: begin
        if (hot_crit) begin
          go = 1'b1; go_mode = MODE_CRITICAL;
        end else if (hot && held && budget) begin
          go = 1'b1; go_mode = MODE_THERMAL;
        end else if (load_high && held && budget) begin
          go = 1'b1; go_mode = MODE_PRESSURE;
        end else if (held && cooled && cpu_low) begin
          if (stage_q < LAST_STAGE) begin
            stage_step = 1'b1;
          end else begin
            go = 1'b1; go_mode = MODE_NORMAL;
          end
        end
      end
      default: begin
        go = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    since_d     = since_q;
    stage_d     = stage_q;
    cd_until_d  = cd_until_q;
    esc_d       = esc_eff;
    win_start_d = roll ? now : win_start_q;
    if (go) begin
      mode_d  = go_mode;
      since_d = now;
      stage_d = 2'd0;
      if ((go_mode == MODE_PRESSURE || go_mode == MODE_THERMAL ||
           go_mode == MODE_CRITICAL) && esc_eff != ESC_COUNT_MAX) begin
        esc_d = esc_eff + 8'd1;
      end
      if (go_mode == MODE_NORMAL) begin
        cd_until_d = cd_end;
      end
    end else if (stage_step) begin
      stage_d = stage_q + 2'd1;
      since_d = now;
    end
  end

  assign tab = table_of(mode_d, stage_d);

  always_comb begin
    res_o.mode               = mode_d;
    res_o.high_tier_interval = tab[0];
    res_o.mid_tier_interval  = tab[2:1];
    res_o.low_tier_interval  = tab[6:3];
    res_o.changed            = (mode_d != mode_q) || (tab != last_tab_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      since_q     <= '0;
      cd_until_q  <= '0;
      win_start_q <= '0;
      esc_q       <= '0;
      stage_q     <= '0;
      last_tab_q  <= '0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      since_q     <= since_d;
      cd_until_q  <= cd_until_d;
      win_start_q <= win_start_d;
      esc_q       <= esc_d;
      stage_q     <= stage_d;
      last_tab_q  <= tab;
    end
  end

  assign stat_o.mode      = mode_q;
  assign stat_o.stage     = stage_q;
  assign stat_o.esc_count = esc_q;

endmodule

@@ sv/thermal_load_throttle_policy_top.sv @@
// ----------------------------------------------------------------------------
// thermal_load_throttle_policy_top
// Thermal / CPU load throttle policy: one mode and tier interval word per
// system sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one sample
//   word: temperature, CPU load, millisecond timestamp. Output channel
//   (out_valid_o / out_stall_i / out_data_o) carries one result word per
//   sample: mode, three tier skip intervals and a changed flag.
//   A sample lands in the input register; the policy decision is a single
//   combinational pass from that register into the output register. One
//   sample per cycle is sustained while the receiver takes every result; the
//   pass sits between the input and output registers and is the only path
//   that sets the rate.
//   When the receiver stalls, the result word holds and the input register
//   keeps one more sample; only then is in_stall_o raised.
//   Reset empties both registers, loads the default thresholds and puts the
//   policy in normal mode with a cleared budget and window.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
//   must write them only while no sample is in flight. The block has no check for it.
// ----------------------------------------------------------------------------
module thermal_load_throttle_policy_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tltp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tltp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  tltp_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output tltp_pkg::out_t                 out_data_o
);
  import tltp_pkg::*;

  cfg_t      cfg;
  in_t       s1_q;
  logic      s1_vld_q, s1_vld_d;
  out_t      out_q, res;
  logic      out_vld_q, out_vld_d;
  logic      adv, fire, in_take;
  pol_stat_t stat;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = s1_vld_q && adv;
  assign in_stall_o = s1_vld_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_vld_d  = in_take || (s1_vld_q && !fire);
  assign out_vld_d = fire || (out_vld_q && out_stall_i);

  tltp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  tltp_policy u_policy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (s1_q),
    .fire_i (fire),
    .res_o  (res),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // a mode move is always flagged as a change
  a_mode_move_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.mode != stat.mode) |=> out_data_o.changed)
    else $error("mode move without changed flag");

  // budget counter grows by at most one per sample
  a_esc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ({1'b0, stat.esc_count} <= {1'b0, $past(stat.esc_count)} + 9'd1))
    else $error("escalation count jumped");

  // critical always pauses the low tier
  a_crit_paused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.mode == MODE_CRITICAL) |->
      (out_data_o.low_tier_interval == PAUSED_INTERVAL && out_data_o.high_tier_interval))
    else $error("critical without paused table");

  // recovery stage stays in range and is zero outside recovery
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.stage <= LAST_STAGE) && (stat.mode == MODE_RECOVERY || stat.stage == 2'd0))
    else $error("recovery stage out of range");

endmodule

@@ dv/tb_thermal_load_throttle_policy_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermal_load_throttle_policy_top
// Self-checking bench for the throttle policy. A directed table walks the
// mode machine through its thresholds, hold times, cooldown and budget; then
// random sample words run under several register settings. Every result word
// is compared field by field with a typed table word or an in-bench model.
// ----------------------------------------------------------------------------
module tb_thermal_load_throttle_policy_top;
  import tltp_pkg::*;

  localparam time_t TS_MAX = '1;

  typedef struct packed {
    logic signed [7:0] temp;
    logic signed [7:0] load;
    time_t             stamp;
    logic              typed;
    out_t              want;
  } row_t;

  // want is filled in only where it is obvious; other rows use the model
  localparam row_t DIR_ROWS [21] = '{
    '{8'sd20,  8'sd10,  48'd0,     1'b1, '{MODE_NORMAL, 1'b0, 2'd0, 4'd0, 1'b0}},
    '{8'sd127, 8'sd100, 48'd10,    1'b1,
      '{MODE_CRITICAL, 1'b1, 2'd3, PAUSED_INTERVAL, 1'b1}},
    '{8'sh80,  8'sh80,  48'd20,    1'b1,
      '{MODE_CRITICAL, 1'b1, 2'd3, PAUSED_INTERVAL, 1'b0}},
    '{8'shFF,  8'shFF,  48'd2010,  1'b1, '{MODE_RECOVERY, 1'b0, 2'd1, 4'd2, 1'b1}},
    '{8'sd70,  8'sd70,  48'd4010,  1'b0, '0},
    '{8'sd70,  8'sd70,  48'd6010,  1'b0, '0},
    '{8'sd70,  8'sd70,  48'd8010,  1'b0, '0},
    '{8'sd85,  8'sd95,  48'd9000,  1'b0, '0},
    '{8'sd80,  8'sd0,   48'd13010, 1'b0, '0},
    '{8'sd94,  8'sd0,   48'd15010, 1'b0, '0},
    '{8'sd95,  8'sd0,   48'd15020, 1'b1,
      '{MODE_CRITICAL, 1'b1, 2'd3, PAUSED_INTERVAL, 1'b1}},
    '{8'sd85,  8'sd0,   48'd17020, 1'b0, '0},
    '{8'sd80,  8'sd0,   48'd19020, 1'b1, '{MODE_RECOVERY, 1'b0, 2'd1, 4'd2, 1'b0}},
    '{8'sd80,  8'sd0,   48'd60000, 1'b0, '0},
    '{8'sd70,  8'sd95,  48'd62000, 1'b0, '0},
    '{8'sd0,   8'sd90,  48'd64000, 1'b0, '0},
    '{8'sd0,   8'sd70,  48'd66000, 1'b0, '0},
    '{8'sd0,   8'sd127, 48'd68000, 1'b0, '0},
    '{8'shFF,  8'shFF,  48'd70000, 1'b0, '0},
    '{8'sd127, 8'sd0,   48'd70010, 1'b1,
      '{MODE_CRITICAL, 1'b1, 2'd3, PAUSED_INTERVAL, 1'b1}},
    '{8'sd0,   8'sd0,   48'd70020, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  in_t                  in_data = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_t                 out_data_o;

  // policy model state
  cfg_t       pol_cfg;
  logic [2:0] pol_mode;
  time_t      pol_since;
  time_t      pol_cool_until;
  time_t      pol_win_start;
  logic [7:0] pol_esc;
  logic [1:0] pol_stage;
  tab_t       pol_last_tab;

  out_t  expected_words [$];
  int    mismatch_count = 0;
  int    idle_pct = 21;
  bit    hold_off_req = 1'b0;
  int    hold_left = 0;
  time_t clock_ms = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  thermal_load_throttle_policy_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------- model

  // packed as {low, mid, high}
  function automatic tab_t skip_table(logic [2:0] m, logic [1:0] stg);
    case (m)
      MODE_PRESSURE: return {4'd2, 2'd1, 1'b0};
      MODE_THERMAL:  return {4'd3, 2'd2, 1'b0};
      MODE_CRITICAL: return {PAUSED_INTERVAL, 2'd3, 1'b1};
      MODE_RECOVERY: begin
        if (stg == 2'd0) return {4'd2, 2'd1, 1'b0};
        if (stg == 2'd1) return {4'd1, 2'd0, 1'b0};
        return '0;
      end
      default:       return '0;
    endcase
  endfunction

  function automatic void policy_reset();
    pol_cfg.crit_enter    = 7'd95;
    pol_cfg.crit_exit     = 7'd85;
    pol_cfg.thermal_enter = 7'd80;
    pol_cfg.thermal_exit  = 7'd70;
    pol_cfg.load_enter    = 7'd90;
    pol_cfg.load_exit     = 7'd70;
    pol_cfg.min_hold      = 32'd2000;
    pol_cfg.cooldown      = 32'd5000;
    pol_mode       = MODE_NORMAL;
    pol_since      = '0;
    pol_cool_until = '0;
    pol_win_start  = '0;
    pol_esc        = '0;
    pol_stage      = '0;
    pol_last_tab   = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    case (idx)
      CFG_CRIT_ENTER:    pol_cfg.crit_enter    = d[6:0];
      CFG_CRIT_EXIT:     pol_cfg.crit_exit     = d[6:0];
      CFG_THERMAL_ENTER: pol_cfg.thermal_enter = d[6:0];
      CFG_THERMAL_EXIT:  pol_cfg.thermal_exit  = d[6:0];
      CFG_LOAD_ENTER:    pol_cfg.load_enter    = d[6:0];
      CFG_LOAD_EXIT:     pol_cfg.load_exit     = d[6:0];
      CFG_MIN_HOLD:      pol_cfg.min_hold      = d;
      default:           pol_cfg.cooldown      = d;
    endcase
  endfunction

  function automatic void enter_mode(logic [2:0] m, time_t now);
    logic [TIME_BITS:0] cd_end;
    if (m == MODE_PRESSURE || m == MODE_THERMAL || m == MODE_CRITICAL) begin
      if (pol_esc != ESC_COUNT_MAX) pol_esc = pol_esc + 8'd1;
    end
    pol_mode  = m;
    pol_since = now;
    pol_stage = '0;
    if (m == MODE_NORMAL) begin
      // cooldown end saturates at the top of the time range
      cd_end = {1'b0, now} + (TIME_BITS + 1)'(pol_cfg.cooldown);
      pol_cool_until = cd_end[TIME_BITS] ? TS_MAX : cd_end[TIME_BITS-1:0];
    end
  endfunction

  function automatic out_t policy_step(in_t s);
    int         t;
    int         l;
    time_t      now;
    logic       hot_crit, hot, cooled, cooled_crit, load_high, cpu_low;
    logic       held, cool_ok, budget;
    logic [2:0] prev_mode;
    tab_t       prev_tab;
    tab_t       tab;
    out_t       r;
    t = s.temperature;
    l = s.cpu_load;
    now = s.timestamp;
    prev_mode = pol_mode;
    prev_tab  = pol_last_tab;
    hot_crit    = t >= 0 && t >= int'(pol_cfg.crit_enter);
    hot         = t >= 0 && t >= int'(pol_cfg.thermal_enter);
    cooled      = t < 0 || t <= int'(pol_cfg.thermal_exit);
    cooled_crit = t < 0 || t <= int'(pol_cfg.crit_exit);
    load_high   = l >= 0 && l >= int'(pol_cfg.load_enter);
    cpu_low     = l < 0 || l <= int'(pol_cfg.load_exit);
    held        = (now - pol_since) >= time_t'(pol_cfg.min_hold);
    cool_ok     = now >= pol_cool_until;
    // window roll: plain compare, no wrap
    if (now >= pol_win_start && now - pol_win_start >= time_t'(ESCALATION_WINDOW_MS)) begin
      pol_win_start = now;
      pol_esc = '0;
    end
    budget = pol_esc < MAX_ESCALATIONS;
    case (pol_mode)
      MODE_NORMAL: begin
        if (hot_crit) enter_mode(MODE_CRITICAL, now);
        else if (cool_ok) begin
          if (hot && held && budget) enter_mode(MODE_THERMAL, now);
          else if (load_high && held && budget) enter_mode(MODE_PRESSURE, now);
        end
      end
      MODE_PRESSURE: begin
        if (hot_crit) enter_mode(MODE_CRITICAL, now);
        else if (hot && held && budget) enter_mode(MODE_THERMAL, now);
        else if (cpu_low && held) enter_mode(MODE_RECOVERY, now);
      end
      MODE_THERMAL: begin
        if (hot_crit) enter_mode(MODE_CRITICAL, now);
        else if (cooled && held) enter_mode(MODE_RECOVERY, now);
      end
      MODE_CRITICAL: begin
        if (cooled_crit && held) enter_mode(MODE_RECOVERY, now);
      end
      MODE_RECOVERY: begin
        if (hot_crit) enter_mode(MODE_CRITICAL, now);
        else if (hot && held && budget) enter_mode(MODE_THERMAL, now);
        else if (load_high && held && budget) enter_mode(MODE_PRESSURE, now);
        else if (held && cooled && cpu_low) begin
          if (pol_stage < LAST_STAGE) begin
            pol_stage = pol_stage + 2'd1;
            pol_since = now;
          end else begin
            enter_mode(MODE_NORMAL, now);
          end
        end
      end
      default: ;
    endcase
    tab = skip_table(pol_mode, pol_stage);
    pol_last_tab = tab;
    r.mode               = pol_mode;
    r.high_tier_interval = tab[0];
    r.mid_tier_interval  = tab[2:1];
    r.low_tier_interval  = tab[6:3];
    r.changed            = (pol_mode != prev_mode) || (tab != prev_tab);
    return r;
  endfunction

  // ------------------------------------------------------------ stimulus

  // missing, below exit, between, near a threshold, above enter, any byte
  function automatic logic [7:0] pick_reading(int lo_exit, int lo_enter,
                                              int hi_exit, int hi_enter);
    int unsigned k;
    int          v;
    k = $urandom_range(0, 9);
    if (k == 0) return {1'b1, 7'($urandom)};
    if (k == 1) return 8'($urandom_range(0, lo_exit));
    if (k == 2) return 8'($urandom_range(lo_exit, lo_enter));
    if (k <= 4) begin
      case ($urandom_range(0, 3))
        0:       v = lo_exit;
        1:       v = lo_enter;
        2:       v = hi_exit;
        default: v = hi_enter;
      endcase
      v = v + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 127) v = 127;
      return 8'(v);
    end
    if (k <= 6) return 8'($urandom_range(lo_enter, 127));
    if (k == 7) return 8'($urandom_range(hi_enter, 127));
    return 8'($urandom);
  endfunction

  function automatic time_t near_value(time_t base);
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 0 && base != '0) return base - 1;
    if (r == 2) return base + 1;
    return base;
  endfunction

  function automatic time_t next_stamp(bit top_range);
    int unsigned k;
    time_t       step;
    k = $urandom_range(0, 99);
    step = '0;
    if (top_range && k < 8) begin
      if (k < 3) clock_ms = TS_MAX;
      else clock_ms = TS_MAX - time_t'($urandom_range(0, 90000));
      return clock_ms;
    end
    if (k < 30) step = time_t'($urandom_range(0, 40));
    else if (k < 55) step = near_value(time_t'(pol_cfg.min_hold));
    else if (k < 65) step = near_value(time_t'(pol_cfg.cooldown));
    else if (k < 75) step = near_value(time_t'(ESCALATION_WINDOW_MS));
    else if (k < 95) step = time_t'($urandom_range(0, 4000));
    else if (k < 98) begin
      clock_ms = time_t'({$urandom(), $urandom()});
      return clock_ms;
    end else begin
      clock_ms = clock_ms - time_t'($urandom_range(1, 100));
      return clock_ms;
    end
    clock_ms = clock_ms + step;
    return clock_ms;
  endfunction

  task automatic send_sample(in_t w, logic typed, out_t want);
    out_t pred;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    pred = policy_step(w);
    expected_words.push_back(typed ? want : pred);
    if ($urandom_range(0, 99) < idle_pct / 2) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic run_random(int n, bit top_range);
    in_t w;
    repeat (n) begin
      w.temperature = pick_reading(pol_cfg.thermal_exit, pol_cfg.thermal_enter,
                                   pol_cfg.crit_exit, pol_cfg.crit_enter);
      w.cpu_load    = pick_reading(pol_cfg.load_exit, pol_cfg.load_enter,
                                   pol_cfg.load_exit, pol_cfg.load_enter);
      w.timestamp   = next_stamp(top_range);
      send_sample(w, 1'b0, '0);
    end
  endtask

  // critical in and out at a frozen time stamp: drives the budget counter
  // up to its saturation point
  task automatic run_bursts(int pairs);
    in_t w;
    repeat (pairs) begin
      w.temperature = 8'($urandom_range(pol_cfg.crit_enter, 127));
      w.cpu_load    = 8'($urandom);
      w.timestamp   = clock_ms;
      send_sample(w, 1'b0, '0);
      w.temperature = 8'($urandom_range(0, pol_cfg.crit_exit));
      w.cpu_load    = 8'($urandom);
      send_sample(w, 1'b0, '0);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      apply_reg(CFG_IDX_W'(i), v[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    in_t              w;
    logic [CFG_W-1:0] v [8];
    int               te, tx, ce, cx, le, lx;
    policy_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      w.temperature = DIR_ROWS[i].temp;
      w.cpu_load    = DIR_ROWS[i].load;
      w.timestamp   = DIR_ROWS[i].stamp;
      send_sample(w, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end
    clock_ms = DIR_ROWS[20].stamp;

    // reset thresholds: a stretch with no gaps, then a long receiver hold-off
    run_random(40, 1'b0);
    idle_pct = 0;
    run_random(60, 1'b0);
    idle_pct = 21;
    hold_off_req = 1'b1;
    run_random(50, 1'b0);

    wait_drained();
    write_regs('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    run_random(30, 1'b0);

    wait_drained();
    write_regs('{32'd127, 32'd127, 32'd127, 32'd127, 32'd127, 32'd127,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    run_random(30, 1'b0);

    // ordered thresholds, junk in the unused upper bits
    repeat (3) begin
      te = $urandom_range(20, 110);
      tx = te - int'($urandom_range(0, 20));
      ce = te + int'($urandom_range(0, 17));
      if (ce > 127) ce = 127;
      cx = $urandom_range(tx, ce);
      le = $urandom_range(30, 110);
      lx = le - int'($urandom_range(0, 30));
      v = '{{25'($urandom), 7'(ce)}, {25'($urandom), 7'(cx)},
            {25'($urandom), 7'(te)}, {25'($urandom), 7'(tx)},
            {25'($urandom), 7'(le)}, {25'($urandom), 7'(lx)},
            32'($urandom_range(0, 3000)), 32'($urandom_range(0, 8000))};
      wait_drained();
      write_regs(v);
      run_random(25, 1'b0);
    end

    // thresholds in any order
    v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          32'($urandom_range(0, 5000)), 32'($urandom_range(0, 9000))};
    wait_drained();
    write_regs(v);
    run_random(25, 1'b0);

    wait_drained();
    write_regs('{32'd95, 32'd85, 32'd80, 32'd70, 32'd90, 32'd70, 32'd0, 32'd0});
    run_bursts(258);
    run_random(20, 1'b0);

    // top of the time range: wrap of the hold time, saturated cooldown end
    wait_drained();
    write_regs('{32'd95, 32'd85, 32'd80, 32'd70, 32'd90, 32'd70,
                 32'd2000, 32'hFFFF_FFFF});
    clock_ms = TS_MAX - time_t'(400000);
    run_random(60, 1'b1);

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word arrived with nothing pending");
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("mode", want.mode, out_data_o.mode);
        check_field("high_tier_interval", want.high_tier_interval,
                    out_data_o.high_tier_interval);
        check_field("mid_tier_interval", want.mid_tier_interval,
                    out_data_o.mid_tier_interval);
        check_field("low_tier_interval", want.low_tier_interval,
                    out_data_o.low_tier_interval);
        check_field("changed", want.changed, out_data_o.changed);
      end
    end
  end

endmodule

@@ files.f @@
sv/tltp_pkg.sv
sv/tltp_cfg_regs.sv
sv/tltp_policy.sv
sv/thermal_load_throttle_policy_top.sv
dv/tb_thermal_load_throttle_policy_top.sv
